// ----- design/teq_pkg.sv -----
// ---------------------------------------------------------------------------
// teq_pkg
// Shared types and constants of the timed event queue.
// ---------------------------------------------------------------------------
package teq_pkg;
  localparam int DEPTH        = 16;
  localparam int TIME_BITS    = 48;
  localparam int HANDLER_BITS = 8;
  localparam int ARG_BITS     = 16;
  localparam int SLOT_BITS    = $clog2(DEPTH);
  localparam int COUNT_BITS   = $clog2(DEPTH + 1);
  localparam int STAMP_BITS   = 32;
  localparam int ENTRY_BITS   = TIME_BITS + HANDLER_BITS + ARG_BITS + STAMP_BITS;
  localparam int US_PER_MS    = 1000;

  localparam logic [2:0] OP_SCHED_REL  = 3'd0;
  localparam logic [2:0] OP_SCHED_ABS  = 3'd1;
  localparam logic [2:0] OP_CANCEL_HND = 3'd2;
  localparam logic [2:0] OP_CANCEL_SIG = 3'd3;
  localparam logic [2:0] OP_EXPIRE     = 3'd4;
  localparam logic [2:0] OP_QUERY      = 3'd5;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_DUP       = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_NONE      = 3'd4;

  typedef struct packed {
    logic [TIME_BITS-1:0]    deadline;
    logic [HANDLER_BITS-1:0] handler;
    logic [ARG_BITS-1:0]     argument;
    logic [STAMP_BITS-1:0]   stamp;
  } entry_t;
endpackage

// ----- design/teq_ram.sv -----
// ---------------------------------------------------------------------------
// teq_ram
// Generic single-port-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module teq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- design/timed_event_queue.sv -----
// ---------------------------------------------------------------------------
// timed_event_queue
// Sixteen-slot store of timed events: schedule, cancel, expire, query.
// ---------------------------------------------------------------------------
// a scan pass reads one slot a cycle, then a decide and an emit state load the
// result word; a relative schedule first passes a multiply and a sum state for
// the deadline, handle cancel goes straight to decide, and an unused op straight
// to emit. one item at a time: in_stall is high until the result word is loaded;
// expire rescans for each further word; output stalls hold the emit state.
// reset clears valid bits and the insert counter; the slot memory is not cleared.
module timed_event_queue (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        in_op,
  input  logic [teq_pkg::TIME_BITS-1:0]     in_now_us,
  input  logic [31:0]                       in_delay_ms,
  input  logic [teq_pkg::TIME_BITS-1:0]     in_abs_time_us,
  input  logic [teq_pkg::HANDLER_BITS-1:0]  in_handler_id,
  input  logic [teq_pkg::ARG_BITS-1:0]      in_argument_id,
  input  logic                              in_reject_duplicate,
  input  logic [teq_pkg::SLOT_BITS-1:0]     in_handle,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [2:0]                        out_status,
  output logic [teq_pkg::SLOT_BITS-1:0]     out_handle,
  output logic [teq_pkg::HANDLER_BITS-1:0]  out_handler_id,
  output logic [teq_pkg::ARG_BITS-1:0]      out_argument_id,
  output logic [teq_pkg::TIME_BITS-1:0]     out_delta_us,
  output logic [teq_pkg::COUNT_BITS-1:0]    out_pending_count,
  output logic                              out_last
);
  localparam int TB = teq_pkg::TIME_BITS;
  localparam int SB = teq_pkg::SLOT_BITS;
  localparam int CB = teq_pkg::COUNT_BITS;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL   = 6'b000010,
    S_SUM   = 6'b000100,
    S_SCAN  = 6'b001000,
    S_DEC   = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [teq_pkg::DEPTH-1:0]     valid_r, valid_nxt;
  logic [31:0]                   icnt_r, icnt_nxt;

  // latched item
  logic [2:0]                    op_r;
  logic [TB-1:0]                 now_r;
  logic [31:0]                   dly_r;
  logic [teq_pkg::HANDLER_BITS-1:0] hid_r;
  logic [teq_pkg::ARG_BITS-1:0]  aid_r;
  logic                          rej_r;
  logic [SB-1:0]                 hnd_r;
  logic [TB+9:0]                 prod_r;
  logic [TB-1:0]                 dl_r;
  logic [4:0]                    nexp_r;

  // scan
  logic [SB:0]                   raddr_r;   // address issued
  logic                          rvld_r;    // rdata belongs to slot rslot_r
  logic [SB-1:0]                 rslot_r;
  logic                          found_r;
  logic [1:0]                    ndue_r;    // due entries seen, saturates at two
  logic [SB-1:0]                 best_r;
  teq_pkg::entry_t               beste_r;

  // output register
  logic                          ov_r;
  logic [2:0]                    st_r;
  logic [SB-1:0]                 oh_r;
  logic [teq_pkg::HANDLER_BITS-1:0] ohid_r;
  logic [teq_pkg::ARG_BITS-1:0]  oaid_r;
  logic [TB-1:0]                 odel_r;
  logic [CB-1:0]                 opc_r;
  logic                          olast_r;

  teq_pkg::entry_t               rdata, wdata;
  logic                          we;
  logic [SB-1:0]                 raddr_mem;

  // lowest free slot and count
  logic              free_any;
  logic [SB-1:0]     free_slot;
  logic [CB-1:0]     cnt;

  teq_ram #(.WIDTH(teq_pkg::ENTRY_BITS), .DEPTH(teq_pkg::DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(free_slot), .wdata(wdata),
    .raddr(raddr_mem), .rdata(rdata)
  );

  // handle cancel reads its slot while the word is taken
  assign raddr_mem = (state_r == S_IDLE) ? in_handle : raddr_r[SB-1:0];
  assign wdata = '{deadline: dl_r, handler: hid_r, argument: aid_r, stamp: icnt_r};

  always_comb begin
    free_any = 1'b0;
    free_slot = '0;
    cnt = '0;
    for (int i = teq_pkg::DEPTH - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_any = 1'b1;
        free_slot = SB'(i);
      end
      cnt = cnt + CB'(valid_r[i]);
    end
  end

  logic is_min;
  assign is_min   = (op_r == teq_pkg::OP_EXPIRE) || (op_r == teq_pkg::OP_QUERY);

  // candidate compare on the entry read this cycle
  logic cand_hit, sig_eq, older;
  logic [31:0] age_c, age_b;
  always_comb begin
    age_c = icnt_r - rdata.stamp;
    age_b = icnt_r - beste_r.stamp;
    older = age_c > age_b;
    sig_eq = (rdata.handler == hid_r) && (rdata.argument == aid_r);
    if (is_min) begin
      cand_hit = !found_r || (rdata.deadline < beste_r.deadline) ||
                 ((rdata.deadline == beste_r.deadline) && older);
    end else begin
      cand_hit = !found_r && sig_eq;
    end
  end

  logic [TB+9:0] sum_w;
  logic [TB-1:0] delta_w;
  assign sum_w   = {10'd0, now_r} + prod_r;
  assign delta_w = (beste_r.deadline > now_r) ? beste_r.deadline - now_r : '0;

  logic out_free;
  assign out_free = !ov_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  // result word load
  logic          load;
  logic          ld_we;
  logic [2:0]    ld_st;
  logic          ld_slot_en;
  logic [TB-1:0] ld_del;
  logic          ld_last;
  logic [CB-1:0] ld_cnt;
  logic [SB-1:0] ld_slot;
  logic [teq_pkg::HANDLER_BITS-1:0] ld_hid;
  logic [teq_pkg::ARG_BITS-1:0]     ld_aid;

  assign we = ld_we;

  always_comb begin
    state_nxt  = state_r;
    valid_nxt  = valid_r;
    icnt_nxt   = icnt_r;
    load       = 1'b0;
    ld_we      = 1'b0;
    ld_st      = teq_pkg::ST_OK;
    ld_slot_en = 1'b0;
    ld_slot    = best_r;
    ld_hid     = beste_r.handler;
    ld_aid     = beste_r.argument;
    ld_del     = '0;
    ld_last    = 1'b1;
    ld_cnt     = cnt;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          priority case (in_op)
            teq_pkg::OP_SCHED_REL: state_nxt = S_MUL;
            teq_pkg::OP_SCHED_ABS, teq_pkg::OP_CANCEL_SIG,
            teq_pkg::OP_EXPIRE, teq_pkg::OP_QUERY: state_nxt = S_SCAN;
            teq_pkg::OP_CANCEL_HND: state_nxt = S_DEC;
            default: state_nxt = S_EMIT;
          endcase
        end
      end
      S_MUL: state_nxt = S_SUM;
      S_SUM: state_nxt = S_SCAN;
      S_SCAN: begin
        if (rvld_r && rslot_r == SB'(teq_pkg::DEPTH - 1)) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          load = 1'b1;
          state_nxt = S_IDLE;
          priority case (op_r)
            teq_pkg::OP_SCHED_REL, teq_pkg::OP_SCHED_ABS: begin
              ld_slot_en = 1'b1;
              if (rej_r && found_r) begin
                ld_st = teq_pkg::ST_DUP;
              end else if (!free_any) begin
                ld_st = teq_pkg::ST_FULL;
                ld_slot_en = 1'b0;
              end else begin
                ld_slot = free_slot;
                ld_hid = hid_r;
                ld_aid = aid_r;
                ld_we = 1'b1;
                valid_nxt[free_slot] = 1'b1;
                icnt_nxt = icnt_r + 32'd1;
                ld_cnt = cnt + CB'(1);
              end
            end
            teq_pkg::OP_CANCEL_HND, teq_pkg::OP_CANCEL_SIG: begin
              if (found_r) begin
                ld_slot_en = 1'b1;
                valid_nxt[best_r] = 1'b0;
                ld_cnt = cnt - CB'(1);
              end else begin
                ld_st = teq_pkg::ST_NOT_FOUND;
              end
            end
            teq_pkg::OP_EXPIRE: begin
              if (found_r && beste_r.deadline < now_r) begin
                ld_slot_en = 1'b1;
                valid_nxt[best_r] = 1'b0;
                ld_cnt = cnt - CB'(1);
                // last when no second due entry was seen or the word limit is hit
                ld_last = (nexp_r == 5'd15) || (ndue_r == 2'd1);
                if (!ld_last) begin
                  state_nxt = S_SCAN;
                end
              end else begin
                ld_st = teq_pkg::ST_NONE;
              end
            end
            teq_pkg::OP_QUERY: begin
              if (found_r) begin
                ld_slot_en = 1'b1;
                ld_del = delta_w;
              end else begin
                ld_st = teq_pkg::ST_NONE;
              end
            end
            default: ld_st = teq_pkg::ST_NOT_FOUND;
          endcase
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      valid_r  <= '0;
      icnt_r   <= '0;
      ov_r     <= 1'b0;
      raddr_r  <= '0;
      rvld_r   <= 1'b0;
      found_r  <= 1'b0;
      ndue_r   <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      icnt_r  <= icnt_nxt;
      if (ov_r && !out_stall) begin
        ov_r <= 1'b0;
      end
      if (load) begin
        ov_r <= 1'b1;
      end
      if (state_r == S_IDLE || (load && state_nxt == S_SCAN)) begin
        raddr_r <= '0;
        rvld_r  <= 1'b0;
        found_r <= 1'b0;
        ndue_r  <= '0;
      end else if (state_r == S_SCAN) begin
        if (raddr_r < (SB+1)'(teq_pkg::DEPTH)) begin
          raddr_r <= raddr_r + (SB+1)'(1);
        end
        rvld_r  <= (raddr_r < (SB+1)'(teq_pkg::DEPTH));
        if (rvld_r && valid_r[rslot_r] && cand_hit) begin
          found_r <= 1'b1;
        end
        if (rvld_r && valid_r[rslot_r] && (rdata.deadline < now_r) &&
            (ndue_r != 2'd2)) begin
          ndue_r <= ndue_r + 2'd1;
        end
      end else if (state_r == S_DEC && op_r == teq_pkg::OP_CANCEL_HND) begin
        found_r <= valid_r[hnd_r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      op_r  <= in_op;
      now_r <= in_now_us;
      dly_r <= in_delay_ms;
      hid_r <= in_handler_id;
      aid_r <= in_argument_id;
      rej_r <= in_reject_duplicate;
      hnd_r <= in_handle;
      dl_r  <= in_abs_time_us;
      nexp_r <= '0;
    end
    if (state_r == S_MUL) begin
      prod_r <= (TB+10)'(dly_r) * (TB+10)'(teq_pkg::US_PER_MS);
    end
    if (state_r == S_SUM) begin
      dl_r <= (sum_w[TB+9:TB] != '0) ? {TB{1'b1}} : sum_w[TB-1:0];
    end
    rslot_r <= raddr_r[SB-1:0];
    if (state_r == S_SCAN && rvld_r && valid_r[rslot_r] && cand_hit) begin
      best_r  <= rslot_r;
      beste_r <= rdata;
    end
    if (state_r == S_DEC && op_r == teq_pkg::OP_CANCEL_HND) begin
      best_r  <= hnd_r;
      beste_r <= rdata;
    end
    if (load) begin
      nexp_r  <= nexp_r + 5'd1;
      st_r    <= ld_st;
      oh_r    <= ld_slot_en ? ld_slot : '0;
      ohid_r  <= ld_slot_en ? ld_hid : '0;
      oaid_r  <= ld_slot_en ? ld_aid : '0;
      odel_r  <= ld_del;
      opc_r   <= ld_cnt;
      olast_r <= ld_last;
    end
  end

  assign out_valid         = ov_r;
  assign out_status        = st_r;
  assign out_handle        = oh_r;
  assign out_handler_id    = ohid_r;
  assign out_argument_id   = oaid_r;
  assign out_delta_us      = odel_r;
  assign out_pending_count = opc_r;
  assign out_last          = olast_r;
endmodule

// ----- tb/sv/timed_event_queue_test.sv -----
// ---------------------------------------------------------------------------
// timed_event_queue_test
// Drives schedule, cancel, expire and query words into the event store,
// predicts every result word from a private copy of the slot state, and
// compares each accepted result field by field, in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module timed_event_queue_test;

  localparam longint unsigned TMAX = (64'd1 << teq_pkg::TIME_BITS) - 1;
  localparam int MAX_EMIT = 16;
  localparam int CYCLE_LIMIT = 400000;
  // op codes with no operation behind them
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  typedef struct {
    logic [2:0]                       op;
    logic [teq_pkg::TIME_BITS-1:0]    now_us;
    logic [31:0]                      delay_ms;
    logic [teq_pkg::TIME_BITS-1:0]    abs_time_us;
    logic [teq_pkg::HANDLER_BITS-1:0] handler_id;
    logic [teq_pkg::ARG_BITS-1:0]     argument_id;
    logic                             reject_duplicate;
    logic [teq_pkg::SLOT_BITS-1:0]    handle;
  } event_cmd_t;

  typedef struct {
    logic [2:0]                       status;
    logic [teq_pkg::SLOT_BITS-1:0]    handle;
    logic [teq_pkg::HANDLER_BITS-1:0] handler_id;
    logic [teq_pkg::ARG_BITS-1:0]     argument_id;
    logic [teq_pkg::TIME_BITS-1:0]    delta_us;
    logic [teq_pkg::COUNT_BITS-1:0]   pending_count;
    logic                             last;
  } event_word_t;

  class event_scoreboard;
    bit                               live[teq_pkg::DEPTH];
    logic [teq_pkg::TIME_BITS-1:0]    deadline[teq_pkg::DEPTH];
    logic [teq_pkg::HANDLER_BITS-1:0] hid[teq_pkg::DEPTH];
    logic [teq_pkg::ARG_BITS-1:0]     aid[teq_pkg::DEPTH];
    logic [31:0]                      stamp[teq_pkg::DEPTH];
    logic [31:0]                      next_stamp;
    event_word_t                      expected_words[$];
    int                               fail_count;

    function void clear();
      foreach (live[i]) live[i] = 0;
      next_stamp = 0;
      expected_words.delete();
      fail_count = 0;
    endfunction

    function int occupancy();
      int n;
      n = 0;
      foreach (live[i]) if (live[i]) n++;
      return n;
    endfunction

    function void push_word(logic [2:0] st, int slot, logic [teq_pkg::TIME_BITS-1:0] dt,
                            bit lst);
      event_word_t w;
      w.status = st;
      w.handle = slot >= 0 ? teq_pkg::SLOT_BITS'(slot) : '0;
      w.handler_id = slot >= 0 ? hid[slot] : '0;
      w.argument_id = slot >= 0 ? aid[slot] : '0;
      w.delta_us = dt;
      w.pending_count = teq_pkg::COUNT_BITS'(occupancy());
      w.last = lst;
      expected_words.push_back(w);
    endfunction

    function int soonest();
      int best;
      best = -1;
      for (int i = 0; i < teq_pkg::DEPTH; i++) begin
        if (!live[i]) continue;
        if (best < 0 || deadline[i] < deadline[best]) best = i;
        else if (deadline[i] == deadline[best] &&
                 (next_stamp - stamp[i]) > (next_stamp - stamp[best])) best = i;
      end
      return best;
    endfunction

    function int match_sig(logic [teq_pkg::HANDLER_BITS-1:0] h,
                           logic [teq_pkg::ARG_BITS-1:0] a);
      for (int i = 0; i < teq_pkg::DEPTH; i++)
        if (live[i] && hid[i] == h && aid[i] == a) return i;
      return -1;
    endfunction

    function void note_command(event_cmd_t c);
      logic [teq_pkg::TIME_BITS-1:0] dl;
      logic [63:0] sum;
      int s, k;
      case (c.op)
        teq_pkg::OP_SCHED_REL, teq_pkg::OP_SCHED_ABS: begin
          sum = 64'(c.now_us) + 64'(c.delay_ms) * 64'(teq_pkg::US_PER_MS);
          dl = c.op == teq_pkg::OP_SCHED_ABS ? c.abs_time_us :
               (sum > TMAX ? teq_pkg::TIME_BITS'(TMAX) : sum[teq_pkg::TIME_BITS-1:0]);
          s = c.reject_duplicate ? match_sig(c.handler_id, c.argument_id) : -1;
          if (s >= 0) begin
            push_word(teq_pkg::ST_DUP, s, 0, 1);
          end else begin
            s = -1;
            for (int i = teq_pkg::DEPTH - 1; i >= 0; i--) if (!live[i]) s = i;
            if (s < 0) push_word(teq_pkg::ST_FULL, -1, 0, 1);
            else begin
              live[s] = 1;
              deadline[s] = dl;
              hid[s] = c.handler_id;
              aid[s] = c.argument_id;
              stamp[s] = next_stamp;
              next_stamp++;
              push_word(teq_pkg::ST_OK, s, 0, 1);
            end
          end
        end
        teq_pkg::OP_CANCEL_HND, teq_pkg::OP_CANCEL_SIG: begin
          if (c.op == teq_pkg::OP_CANCEL_HND) s = live[c.handle] ? int'(c.handle) : -1;
          else s = match_sig(c.handler_id, c.argument_id);
          if (s < 0) push_word(teq_pkg::ST_NOT_FOUND, -1, 0, 1);
          else begin
            live[s] = 0;
            push_word(teq_pkg::ST_OK, s, 0, 1);
          end
        end
        teq_pkg::OP_EXPIRE: begin
          k = 0;
          while (k < MAX_EMIT) begin
            s = soonest();
            if (s < 0 || !(deadline[s] < c.now_us)) break;
            live[s] = 0;
            push_word(teq_pkg::ST_OK, s, 0, 0);
            k++;
          end
          if (k == 0) push_word(teq_pkg::ST_NONE, -1, 0, 1);
          else expected_words[$].last = 1;
        end
        teq_pkg::OP_QUERY: begin
          s = soonest();
          if (s < 0) push_word(teq_pkg::ST_NONE, -1, 0, 1);
          else push_word(teq_pkg::ST_OK, s,
                         deadline[s] > c.now_us ? deadline[s] - c.now_us : '0, 1);
        end
        default: push_word(teq_pkg::ST_NOT_FOUND, -1, 0, 1);
      endcase
    endfunction

    function void check_word(event_word_t got);
      event_word_t e;
      if (expected_words.size() == 0) begin
        $error("unexpected result word, status %0d", got.status);
        fail_count++;
        return;
      end
      e = expected_words.pop_front();
      if (got.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, got.status); fail_count++;
      end
      if (got.handle !== e.handle) begin
        $error("out_handle: expected %0d, got %0d", e.handle, got.handle); fail_count++;
      end
      if (got.handler_id !== e.handler_id) begin
        $error("out_handler_id: expected %0h, got %0h", e.handler_id, got.handler_id);
        fail_count++;
      end
      if (got.argument_id !== e.argument_id) begin
        $error("out_argument_id: expected %0h, got %0h", e.argument_id, got.argument_id);
        fail_count++;
      end
      if (got.delta_us !== e.delta_us) begin
        $error("delta_us: expected %0d, got %0d", e.delta_us, got.delta_us); fail_count++;
      end
      if (got.pending_count !== e.pending_count) begin
        $error("pending_count: expected %0d, got %0d", e.pending_count, got.pending_count);
        fail_count++;
      end
      if (got.last !== e.last) begin
        $error("last: expected %0d, got %0d", e.last, got.last); fail_count++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [2:0] in_op = 0;
  logic [teq_pkg::TIME_BITS-1:0] in_now_us = 0;
  logic [31:0] in_delay_ms = 0;
  logic [teq_pkg::TIME_BITS-1:0] in_abs_time_us = 0;
  logic [teq_pkg::HANDLER_BITS-1:0] in_handler_id = 0;
  logic [teq_pkg::ARG_BITS-1:0] in_argument_id = 0;
  logic in_reject_duplicate = 0;
  logic [teq_pkg::SLOT_BITS-1:0] in_handle = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [2:0] out_status;
  logic [teq_pkg::SLOT_BITS-1:0] out_handle;
  logic [teq_pkg::HANDLER_BITS-1:0] out_handler_id;
  logic [teq_pkg::ARG_BITS-1:0] out_argument_id;
  logic [teq_pkg::TIME_BITS-1:0] out_delta_us;
  logic [teq_pkg::COUNT_BITS-1:0] out_pending_count;
  logic out_last;

  event_scoreboard board = new();
  bit quiet_tail = 0;
  int cycles = 0;
  logic [teq_pkg::TIME_BITS-1:0] clock_now = 0;

  always #6 clk = ~clk;

  timed_event_queue u_top (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timed_event_queue_test: errors");
      $finish;
    end
  end

  // result side: sample at rising edge, random stall bursts
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_word('{out_status, out_handle, out_handler_id, out_argument_id,
                         out_delta_us, out_pending_count, out_last});
  end

  initial begin
    int burst;
    forever begin
      @(negedge clk);
      if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 6);
        out_stall <= 1;
        repeat (burst) @(negedge clk);
      end
      out_stall <= 0;
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(event_cmd_t c);
    int burst;
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      burst = $urandom_range(1, 6);
      in_valid <= 0;
      repeat (burst) @(negedge clk);
    end
    in_op <= c.op;
    in_now_us <= c.now_us;
    in_delay_ms <= c.delay_ms;
    in_abs_time_us <= c.abs_time_us;
    in_handler_id <= c.handler_id;
    in_argument_id <= c.argument_id;
    in_reject_duplicate <= c.reject_duplicate;
    in_handle <= c.handle;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    board.note_command(c);
    @(negedge clk);
  endtask

  function automatic event_cmd_t make_word(logic [2:0] op);
    event_cmd_t c;
    c.op = op;
    c.now_us = clock_now;
    c.delay_ms = $urandom_range(0, 30);
    c.abs_time_us = clock_now + teq_pkg::TIME_BITS'($urandom_range(0, 40000));
    // small id space so duplicates and signature hits happen
    c.handler_id = teq_pkg::HANDLER_BITS'($urandom_range(0, 3));
    c.argument_id = teq_pkg::ARG_BITS'($urandom_range(0, 3));
    c.reject_duplicate = 1'($urandom_range(0, 1));
    c.handle = teq_pkg::SLOT_BITS'($urandom_range(0, teq_pkg::DEPTH - 1));
    return c;
  endfunction

  task automatic send_rand(event_cmd_t c);
    if ($urandom_range(0, 9) == 0) begin
      c.now_us = teq_pkg::TIME_BITS'({$urandom, $urandom});
      c.delay_ms = $urandom;
      c.abs_time_us = teq_pkg::TIME_BITS'({$urandom, $urandom});
      c.handler_id = teq_pkg::HANDLER_BITS'($urandom);
      c.argument_id = teq_pkg::ARG_BITS'($urandom);
    end
    send_word(c);
  endtask

  initial begin
    event_cmd_t c;
    int pick;
    board.clear();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed: empty store cases
    send_word(make_word(teq_pkg::OP_QUERY));
    send_word(make_word(teq_pkg::OP_EXPIRE));
    c = make_word(teq_pkg::OP_CANCEL_HND); send_word(c);
    c = make_word(teq_pkg::OP_CANCEL_SIG); send_word(c);
    c = make_word(OP_SPARE_LO); send_word(c);
    c = make_word(OP_SPARE_HI); send_word(c);
    // saturating relative deadline and extremes
    c = make_word(teq_pkg::OP_SCHED_REL);
    c.now_us = teq_pkg::TIME_BITS'(TMAX); c.delay_ms = '1;
    c.handler_id = '1; c.argument_id = '1;
    send_word(c);
    c = make_word(teq_pkg::OP_SCHED_ABS);
    c.abs_time_us = 0; c.handler_id = 0; c.argument_id = 0; send_word(c);
    c = make_word(teq_pkg::OP_SCHED_ABS);
    c.abs_time_us = 0; c.handler_id = 0; c.argument_id = 0; c.reject_duplicate = 1;
    send_word(c);
    c.reject_duplicate = 0; send_word(c);
    // fill the store, then one more for the full case
    for (int i = 0; i < 13; i++) begin
      c = make_word(teq_pkg::OP_SCHED_ABS); c.reject_duplicate = 0;
      c.abs_time_us = teq_pkg::TIME_BITS'(i % 3); send_word(c);
    end
    c = make_word(teq_pkg::OP_SCHED_REL); c.reject_duplicate = 0; send_word(c);
    c = make_word(teq_pkg::OP_QUERY); c.now_us = 1000; send_word(c);
    c = make_word(teq_pkg::OP_EXPIRE); c.now_us = 5; send_word(c);
    c = make_word(teq_pkg::OP_EXPIRE); c.now_us = teq_pkg::TIME_BITS'(TMAX); send_word(c);

    for (int n = 0; n < 195; n++) begin
      if (n == 160) quiet_tail = 1;
      clock_now = clock_now + teq_pkg::TIME_BITS'($urandom_range(0, 8000));
      pick = $urandom_range(0, 19);
      if (pick < 8) c = make_word(pick < 4 ? teq_pkg::OP_SCHED_REL : teq_pkg::OP_SCHED_ABS);
      else if (pick < 11) c = make_word(teq_pkg::OP_CANCEL_HND);
      else if (pick < 13) c = make_word(teq_pkg::OP_CANCEL_SIG);
      else if (pick < 16) c = make_word(teq_pkg::OP_EXPIRE);
      else if (pick < 19) c = make_word(teq_pkg::OP_QUERY);
      else c = make_word(3'($urandom_range(6, 7)));
      send_rand(c);
    end
    in_valid <= 0;

    while (board.expected_words.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (board.fail_count == 0) $display("timed_event_queue_test: clean");
    else $display("timed_event_queue_test: errors");
    $finish;
  end
endmodule
